// ===== rtl/mah_pkg.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header parser package
// Field codes, lookup tables, the pipeline record and the per-stage logic.
// ----------------------------------------------------------------------------
package mah_pkg;

  localparam logic [10:0] SYNC_WORD = 11'h7FF;

  localparam logic [1:0] VER_25  = 2'b00;
  localparam logic [1:0] VER_RES = 2'b01;
  localparam logic [1:0] VER_2   = 2'b10;
  localparam logic [1:0] VER_1   = 2'b11;

  localparam logic [1:0] LAYER_RES = 2'b00;
  localparam logic [1:0] LAYER_3   = 2'b01;
  localparam logic [1:0] LAYER_2   = 2'b10;
  localparam logic [1:0] LAYER_1   = 2'b11;

  localparam logic [1:0] MODE_MONO = 2'b11;

  localparam logic [2:0] FULL_HEADER_BYTES = 3'd4;

  // Frame coefficients: samples * 125 / slot for the MPEG-1 rate of each layer.
  localparam logic [19:0] COEF_LAYER1   = 20'd12000;
  localparam logic [19:0] COEF_HALF     = 20'd72000;
  localparam logic [19:0] COEF_FULL     = 20'd144000;

  localparam int RecipShift = 27;

  // Base (MPEG-1) sampling rates; the lower versions divide these by two or four.
  localparam logic [15:0] BASE_RATE [3] = '{16'd44100, 16'd48000, 16'd32000};

  // floor(2^27 / base rate), so that quotient estimates are low by at most one.
  localparam logic [12:0] RECIP [3] = '{
    13'((2 ** RecipShift) / 44100),
    13'((2 ** RecipShift) / 48000),
    13'((2 ** RecipShift) / 32000)
  };

  localparam logic [8:0] KBPS [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
    },
    '{
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
    }
  };

  localparam logic [10:0] SPF [2][3] = '{
    '{11'd1152, 11'd1152, 11'd384},
    '{11'd576, 11'd1152, 11'd384}
  };

  localparam logic [15:0] RATE [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  typedef struct packed {
    logic        ok;
    logic [1:0]  layer;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [10:0] spf;
    logic        pad;
    logic        slot4;
    logic [1:0]  sri;
    logic [26:0] num;
    logic [39:0] work;
    logic [11:0] quot;
  } mah_pipe_t;

  // Field extraction, validity checks, table lookups and the dividend.
  function automatic mah_pipe_t mah_decode(logic [31:0] w, logic [2:0] present);
    mah_pipe_t   p;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        v2;
    logic [1:0]  li;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic [19:0] coef;
    logic [28:0] full;
    logic        ok;
    ver  = w[20:19];
    lay  = w[18:17];
    bri  = w[15:12];
    sri  = w[11:10];
    v2   = (ver != VER_1);
    li   = (lay == LAYER_RES) ? 2'd0 : lay - 2'd1;
    kbps = KBPS[v2][li][bri];
    rate = RATE[ver][sri];
    ok   = (present >= FULL_HEADER_BYTES) && (w[31:21] == SYNC_WORD) &&
           (ver != VER_RES) && (lay != LAYER_RES) && (kbps != 9'd0) && (rate != 16'd0);
    if (lay == LAYER_1) begin
      coef = COEF_LAYER1;
    end else if (v2 && (lay == LAYER_3)) begin
      coef = COEF_HALF;
    end else begin
      coef = COEF_FULL;
    end
    unique case (ver)
      VER_2:   coef = coef << 1;
      VER_25:  coef = coef << 2;
      default: coef = coef;
    endcase
    full    = 29'(kbps) * 29'(coef);
    p       = '0;
    if (ok) begin
      p.ok    = 1'b1;
      p.layer = 2'd0 - lay;
      p.rate  = rate;
      p.chans = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
      p.spf   = SPF[v2][li];
      p.pad   = w[9];
      p.slot4 = (lay == LAYER_1);
      p.sri   = sri;
      p.num   = full[26:0];
    end
    return p;
  endfunction

  // Quotient estimate by the reciprocal of the base rate.
  function automatic mah_pipe_t mah_recip(mah_pipe_t p);
    mah_pipe_t r;
    r      = p;
    r.work = 40'(p.num) * 40'(RECIP[p.sri]);
    return r;
  endfunction

  // Keeps the estimate and multiplies it back by the divisor.
  function automatic mah_pipe_t mah_back(mah_pipe_t p);
    mah_pipe_t r;
    r      = p;
    r.quot = p.work[38:27];
    r.work = 40'(28'(p.work[38:27]) * 28'(BASE_RATE[p.sri]));
    return r;
  endfunction

  // Corrects the estimate by one where needed, adds padding, scales by slot.
  function automatic mah_pipe_t mah_fix(mah_pipe_t p);
    mah_pipe_t   r;
    logic [26:0] rem;
    logic [11:0] q;
    logic [11:0] sum;
    r   = p;
    rem = p.num - p.work[26:0];
    q   = (rem >= 27'(BASE_RATE[p.sri])) ? p.quot + 12'd1 : p.quot;
    sum = q + 12'(p.pad);
    r.quot = p.slot4 ? {sum[9:0], 2'b00} : sum;
    return r;
  endfunction

endpackage

// ===== rtl/mah_if.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header parser channels
// Valid/ready channels for header requests and parse results.
// ----------------------------------------------------------------------------
interface mah_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [2:0]  bytes_present;

  modport source(output valid, header_word, bytes_present, input ready);
  modport sink(input valid, header_word, bytes_present, output ready);
endinterface

interface mah_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [1:0]  layer_number;
  logic [15:0] sample_rate_hz;
  logic [1:0]  channels;
  logic [10:0] frame_samples;
  logic [11:0] frame_bytes;

  modport source(output valid, header_valid, layer_number, sample_rate_hz, channels,
                 frame_samples, frame_bytes, input ready);
  modport sink(input valid, header_valid, layer_number, sample_rate_hz, channels,
               frame_samples, frame_bytes, output ready);
endinterface

// ===== rtl/mah_cell.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header parser cell
// One slot of the parse chain: holds a request record and hands it on.
// ----------------------------------------------------------------------------
module mah_cell
  import mah_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mah_pipe_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mah_pipe_t out_data
);

  logic      full;
  mah_pipe_t data;

  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// ===== rtl/mpeg_audio_frame_header_parse_core.sv =====
// ----------------------------------------------------------------------------
// MPEG audio frame header parser
// Validates a candidate MPEG-1/2/2.5 audio header and reports its frame layout.
// ----------------------------------------------------------------------------
// The core accepts one header request per cycle while its input is not stalled
// and passes it through a chain of four identical cells: decode and table
// lookup, reciprocal multiply by the base sampling rate, multiply-back, and a
// final correction that adds padding and scales Layer I slots. Each cell
// stalls only when it is full and the one after it is stalled, so the input
// keeps flowing while a finished result waits at the output until all cells fill.
module mpeg_audio_frame_header_parse_core
  import mah_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mah_in_if.sink     hdr,
  mah_out_if.source  res
);

  localparam int Cells = 4;

  logic      vin  [Cells];
  logic      rin  [Cells];
  logic      vout [Cells];
  logic      rout [Cells];
  mah_pipe_t cin  [Cells];
  mah_pipe_t cout [Cells];
  mah_pipe_t last;

  genvar i;
  generate
    for (i = 0; i < Cells; i++) begin : g_cell
      mah_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (vin[i]),
        .in_ready  (rin[i]),
        .in_data   (cin[i]),
        .out_valid (vout[i]),
        .out_ready (rout[i]),
        .out_data  (cout[i])
      );
    end
  endgenerate

  always_comb begin
    vin[0]    = hdr.valid;
    cin[0]    = mah_decode(hdr.header_word, hdr.bytes_present);
    vin[1]    = vout[0];
    cin[1]    = mah_recip(cout[0]);
    vin[2]    = vout[1];
    cin[2]    = mah_back(cout[1]);
    vin[3]    = vout[2];
    cin[3]    = mah_fix(cout[2]);
    rout[0]   = rin[1];
    rout[1]   = rin[2];
    rout[2]   = rin[3];
    rout[3]   = res.ready;
  end

  assign hdr.ready = rin[0];
  assign last      = cout[Cells - 1];

  assign res.valid          = vout[Cells - 1];
  assign res.header_valid   = last.ok;
  assign res.layer_number   = last.layer;
  assign res.sample_rate_hz = last.rate;
  assign res.channels       = last.chans;
  assign res.frame_samples  = last.spf;
  assign res.frame_bytes    = last.quot;

  // A stalled input can only come from a result held at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !hdr.ready |-> (res.valid && !res.ready))
    else $error("input stalled without a held result");

  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.header_valid) |->
      (res.frame_bytes != 12'd0 && res.frame_samples != 11'd0 &&
       res.layer_number != 2'd0 && res.sample_rate_hz != 16'd0))
    else $error("valid header with an empty field");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.header_valid) |->
      (res.frame_bytes == 12'd0 && res.sample_rate_hz == 16'd0 &&
       res.channels == 2'd0 && res.frame_samples == 11'd0))
    else $error("rejected header with nonzero fields");

endmodule
